/* rtl/table_interpolator_core_macros.svh */
// Assertion macros used by the table interpolator datapath.
`ifndef TABLE_INTERPOLATOR_CORE_MACROS_SVH
`define TABLE_INTERPOLATOR_CORE_MACROS_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define TIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define TIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tic_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the table interpolator.
`default_nettype none

package tic_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int PC_W        = 7;
  localparam int ACC_W       = 40;
  localparam int PROD_W      = ACC_W + FRAC_BITS + 1;
  localparam int DIV_CW      = $clog2(FRAC_BITS + 1);

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FEW    = 2'd1;
  localparam logic [1:0] ST_ORDER  = 2'd2;
  localparam logic [1:0] ST_METHOD = 2'd3;

  localparam logic [1:0] METH_LINEAR  = 2'd0;
  localparam logic [1:0] METH_CUBIC   = 2'd1;
  localparam logic [1:0] METH_NEAREST = 2'd2;
  localparam logic [1:0] METH_BAD     = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    MODE_CLAMP,
    MODE_NEAR,
    MODE_LIN,
    MODE_CUB
  } tic_mode_e;

  typedef struct packed {
    logic wr_entry;
    logic q_load;
    logic scan_step;
    logic decide;
    logic gather_step;
    logic select;
    logic div_start;
    logic prep;
    logic mul;
    logic acc;
    logic result;
    logic out_load;
  } tic_cmd_t;

  typedef struct packed {
    logic      scan_done;
    logic      gather_done;
    logic      err;
    tic_mode_e mode;
    logic      div_done;
    logic      acc_last;
    logic      out_busy;
  } tic_sts_t;

endpackage

`default_nettype wire

/* rtl/tic_div.sv */
// Restoring divider that produces the segment fraction one quotient bit per cycle.
`default_nettype none

module tic_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire [tic_pkg::DATA_W-1:0]    num_i,
  input  wire [tic_pkg::DATA_W-1:0]    den_i,
  output logic [tic_pkg::FRAC_BITS-1:0] quo_o,
  output logic                         done_o
);
  import tic_pkg::*;

  logic [DATA_W:0]    rem_q, rem_d;
  logic [FRAC_BITS-1:0] quo_q, quo_d;
  logic [DIV_CW-1:0]  cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [DATA_W:0]    shifted;
  logic [DATA_W:0]    den_ext;

  assign shifted = {rem_q[DATA_W-1:0], 1'b0};
  assign den_ext = {1'b0, den_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      quo_d  = '0;
      cnt_d  = DIV_CW'(FRAC_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= den_ext) begin
        rem_d = shifted - den_ext;
        quo_d = {quo_q[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[FRAC_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_CW'(1);
      if (cnt_q == DIV_CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quo_o  = quo_q;
  assign done_o = !busy_q;

endmodule

`default_nettype wire

/* rtl/tic_ctrl.sv */
// Sequencing state machine of the table interpolator.
`default_nettype none

module tic_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               in_cmd_i,
  output logic              in_ready_o,
  input  tic_pkg::tic_sts_t sts_i,
  output tic_pkg::tic_cmd_t cmd_o
);
  import tic_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_GATHER = 4'd3;
  localparam logic [3:0] S_SELECT = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_PREP   = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_ACC    = 4'd8;
  localparam logic [3:0] S_RESULT = 4'd9;
  localparam logic [3:0] S_FINISH = 4'd10;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (in_cmd_i == CMD_WRITE)) begin
          cmd_o.wr_entry = 1'b1;
        end
        if (accept && (in_cmd_i == CMD_QUERY)) begin
          cmd_o.q_load = 1'b1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.err ? S_FINISH : S_GATHER;
      end
      S_GATHER: begin
        cmd_o.gather_step = 1'b1;
        if (sts_i.gather_done) begin
          state_d = S_SELECT;
        end
      end
      S_SELECT: begin
        cmd_o.select = 1'b1;
        if ((sts_i.mode == MODE_LIN) || (sts_i.mode == MODE_CUB)) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.acc_last ? S_RESULT : S_MUL;
      end
      S_RESULT: begin
        cmd_o.result = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/tic_dp.sv */
// Datapath of the table interpolator: breakpoint memories, scan, divider, multiplier, output register.
`default_nettype none

`include "table_interpolator_core_macros.svh"

module tic_dp (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  tic_pkg::tic_cmd_t                cmd_i,
  output tic_pkg::tic_sts_t                sts_o,
  input  wire                              cfg_we_i,
  input  wire [tic_pkg::PC_W-1:0]          cfg_wdata_i,
  input  wire [tic_pkg::IDX_W-1:0]         in_index_i,
  input  wire signed [tic_pkg::DATA_W-1:0] in_x_i,
  input  wire signed [tic_pkg::DATA_W-1:0] in_y_i,
  input  wire signed [tic_pkg::DATA_W-1:0] in_target_i,
  input  wire [1:0]                        in_method_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [tic_pkg::DATA_W-1:0]       out_value_o,
  output logic [1:0]                       out_status_o
);
  import tic_pkg::*;

  logic signed [DATA_W-1:0] x_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] y_mem [TABLE_DEPTH];

  logic [PC_W-1:0]          pc_q;
  logic [CNT_W-1:0]         n_w, nm1;
  logic signed [DATA_W-1:0] tgt_q;
  logic [1:0]               meth_q;

  logic [CNT_W-1:0]         cnt_q;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic                     rd_vld_q, rd_gath_q;
  logic [CNT_W-1:0]         rd_tag_q;
  logic signed [DATA_W-1:0] x_rd_q, y_rd_q;

  logic signed [DATA_W-1:0] x0_q, xl_q, prev_q;
  logic                     bad_q;
  logic [CNT_W-1:0]         seg_q, r_q, r_m1;

  logic [IDX_W-1:0]         g_q [4];
  logic [IDX_W-1:0]         gi, g0, g2, g3;
  tic_mode_e                mode_q, mode_w;
  logic                     err;
  logic [1:0]               err_code;

  logic signed [DATA_W-1:0] ya_q [4];
  logic signed [DATA_W-1:0] xa1_q, xa2_q;
  logic [1:0]               status_q;
  logic signed [DATA_W-1:0] res_q;

  logic signed [DATA_W:0]   ld, rdist, num_full, den_full;
  logic [FRAC_BITS-1:0]     t_w;
  logic                     div_done;

  logic signed [ACC_W-1:0]  e0, e1, e2, e3, b0, b1, b2;
  logic signed [ACC_W-1:0]  h_q, b1_q, b2_q, addend, p_sh;
  logic signed [PROD_W-1:0] p_q;
  logic [1:0]               step_q;
  logic signed [ACC_W:0]    h_adj;
  logic signed [ACC_W:0]    sum;
  logic                     ovf;

  logic                     out_vld_q;
  logic [DATA_W-1:0]        out_val_q;
  logic [1:0]               out_st_q;

  // Point count, limited to the table depth.
  assign n_w   = (pc_q > PC_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : pc_q[CNT_W-1:0];
  assign nm1   = n_w - CNT_W'(1);
  assign r_m1  = r_q - CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (cfg_we_i) begin
      pc_q <= cfg_wdata_i;
    end
  end

  // Read issue: scan walks every active entry, gather fetches four chosen ones.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_q[IDX_W-1:0];
    if (cmd_i.scan_step && (cnt_q < n_w)) begin
      rd_en = 1'b1;
    end
    if (cmd_i.gather_step && (cnt_q < CNT_W'(4))) begin
      rd_en   = 1'b1;
      rd_addr = g_q[cnt_q[1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry) begin
      x_mem[in_index_i] <= in_x_i;
      y_mem[in_index_i] <= in_y_i;
    end
    if (rd_en) begin
      x_rd_q <= x_mem[rd_addr];
      y_rd_q <= y_mem[rd_addr];
    end
  end

  // Error and mode decision from the scan summary.
  always_comb begin
    err      = 1'b0;
    err_code = ST_OK;
    if (n_w < CNT_W'(2)) begin
      err      = 1'b1;
      err_code = ST_FEW;
    end else if (bad_q) begin
      err      = 1'b1;
      err_code = ST_ORDER;
    end else if (meth_q == METH_BAD) begin
      err      = 1'b1;
      err_code = ST_METHOD;
    end
  end

  always_comb begin
    mode_w = MODE_CLAMP;
    gi     = '0;
    if (meth_q == METH_NEAREST) begin
      if (r_q == '0) begin
        gi = '0;
      end else if (r_q == n_w) begin
        gi = nm1[IDX_W-1:0];
      end else begin
        mode_w = MODE_NEAR;
        gi     = r_m1[IDX_W-1:0];
      end
    end else begin
      if (tgt_q <= x0_q) begin
        gi = '0;
      end else if (tgt_q >= xl_q) begin
        gi = nm1[IDX_W-1:0];
      end else begin
        gi     = seg_q[IDX_W-1:0];
        mode_w = ((meth_q == METH_CUBIC) && (n_w >= CNT_W'(4))) ? MODE_CUB : MODE_LIN;
      end
    end
    g0 = gi;
    g2 = gi;
    g3 = gi;
    if (mode_w != MODE_CLAMP) begin
      g2 = gi + IDX_W'(1);
      g3 = gi + IDX_W'(1);
    end
    if (mode_w == MODE_CUB) begin
      if (gi != '0) begin
        g0 = gi - IDX_W'(1);
      end
      if (({1'b0, gi} + CNT_W'(2)) < n_w) begin
        g3 = gi + IDX_W'(2);
      end
    end
  end

  // Control state of the scan and sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_gath_q <= 1'b0;
      rd_tag_q  <= '0;
      bad_q     <= 1'b0;
      seg_q     <= '0;
      r_q       <= '0;
      mode_q    <= MODE_CLAMP;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= rd_en;
      rd_gath_q <= cmd_i.gather_step;
      rd_tag_q  <= cnt_q;
      if (rd_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.q_load) begin
        cnt_q <= '0;
        bad_q <= 1'b0;
        seg_q <= '0;
        r_q   <= '0;
      end
      if (rd_vld_q && !rd_gath_q) begin
        if ((rd_tag_q != '0) && (x_rd_q <= prev_q)) begin
          bad_q <= 1'b1;
        end
        if ((rd_tag_q != '0) && (rd_tag_q < nm1) && (x_rd_q <= tgt_q)) begin
          seg_q <= seg_q + CNT_W'(1);
        end
        if (x_rd_q < tgt_q) begin
          r_q <= r_q + CNT_W'(1);
        end
      end
      if (cmd_i.decide) begin
        cnt_q  <= '0;
        mode_q <= mode_w;
      end
      if (cmd_i.prep) begin
        step_q <= '0;
      end
      if (cmd_i.acc) begin
        step_q <= step_q + 2'd1;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.q_load) begin
      tgt_q  <= in_target_i;
      meth_q <= in_method_i;
    end
    if (rd_vld_q && !rd_gath_q) begin
      if (rd_tag_q == '0) begin
        x0_q <= x_rd_q;
      end
      if (rd_tag_q == nm1) begin
        xl_q <= x_rd_q;
      end
      prev_q <= x_rd_q;
    end
    if (rd_vld_q && rd_gath_q) begin
      ya_q[rd_tag_q[1:0]] <= y_rd_q;
      if (rd_tag_q[1:0] == 2'd1) begin
        xa1_q <= x_rd_q;
      end
      if (rd_tag_q[1:0] == 2'd2) begin
        xa2_q <= x_rd_q;
      end
    end
    if (cmd_i.decide) begin
      status_q <= err_code;
      res_q    <= '0;
      g_q[0]   <= g0;
      g_q[1]   <= gi;
      g_q[2]   <= g2;
      g_q[3]   <= g3;
    end
    if (cmd_i.select) begin
      if (mode_q == MODE_NEAR) begin
        res_q <= (ld <= rdist) ? ya_q[1] : ya_q[2];
      end else begin
        res_q <= ya_q[1];
      end
    end
    if (cmd_i.prep) begin
      h_q  <= (mode_q == MODE_CUB) ? b0 : (e2 - e1);
      b1_q <= b1;
      b2_q <= b2;
    end
    if (cmd_i.mul) begin
      p_q <= h_q * $signed({1'b0, t_w});
    end
    if (cmd_i.acc) begin
      h_q <= p_sh + addend;
    end
    if (cmd_i.result) begin
      if (ovf) begin
        res_q <= sum[ACC_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        res_q <= sum[DATA_W-1:0];
      end
    end
    if (cmd_i.out_load) begin
      out_val_q <= res_q;
      out_st_q  <= status_q;
    end
  end

  // Nearest distances and divider operands.
  assign ld       = {tgt_q[DATA_W-1], tgt_q} - {xa1_q[DATA_W-1], xa1_q};
  assign rdist    = {xa2_q[DATA_W-1], xa2_q} - {tgt_q[DATA_W-1], tgt_q};
  assign num_full = ld;
  assign den_full = {xa2_q[DATA_W-1], xa2_q} - {xa1_q[DATA_W-1], xa1_q};

  tic_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_full[DATA_W-1:0]),
    .den_i   (den_full[DATA_W-1:0]),
    .quo_o   (t_w),
    .done_o  (div_done)
  );

  // Doubled Catmull-Rom coefficients.
  assign e0 = ACC_W'(ya_q[0]);
  assign e1 = ACC_W'(ya_q[1]);
  assign e2 = ACC_W'(ya_q[2]);
  assign e3 = ACC_W'(ya_q[3]);
  assign b0 = (e3 - e0) + ((e1 - e2) <<< 1) + (e1 - e2);
  assign b1 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign b2 = e2 - e0;

  assign p_sh = ACC_W'(p_q >>> FRAC_BITS);

  always_comb begin
    case (step_q)
      2'd0:    addend = (mode_q == MODE_CUB) ? b1_q : '0;
      2'd1:    addend = b2_q;
      default: addend = '0;
    endcase
  end

  // Halve the cubic sum with a floor shift; the sign must be kept.
  assign h_adj = (mode_q == MODE_CUB) ? ($signed({h_q[ACC_W-1], h_q}) >>> 1)
                                      : $signed({h_q[ACC_W-1], h_q});
  assign sum = {e1[ACC_W-1], e1} + h_adj;
  assign ovf = !((&sum[ACC_W:DATA_W-1]) || (~|sum[ACC_W:DATA_W-1]));

  assign sts_o.scan_done   = (cnt_q == n_w) && !rd_vld_q;
  assign sts_o.gather_done = (cnt_q == CNT_W'(4)) && !rd_vld_q;
  assign sts_o.err         = err;
  assign sts_o.mode        = mode_q;
  assign sts_o.div_done    = div_done;
  assign sts_o.acc_last    = (mode_q != MODE_CUB) || (step_q == 2'd2);
  assign sts_o.out_busy    = out_vld_q;

  assign out_valid_o  = out_vld_q;
  assign out_value_o  = out_val_q;
  assign out_status_o = out_st_q;

  `TIC_ASSERT_IMP(a_err_value_zero, out_vld_q && (out_st_q != ST_OK), out_val_q == '0, "error result carries a nonzero value")
  `TIC_ASSERT_IMP(a_cubic_needs_four, cmd_i.prep && (mode_q == MODE_CUB), n_w >= CNT_W'(4), "cubic evaluation with fewer than four points")
  `TIC_ASSERT_IMP(a_segment_adjacent, cmd_i.select && (mode_q != MODE_CLAMP), g_q[2] == g_q[1] + IDX_W'(1), "segment ends not adjacent")
  `TIC_ASSERT_NXT(a_out_loaded, cmd_i.out_load, out_vld_q, "loaded result not presented")

endmodule

`default_nettype wire

/* rtl/table_interpolator_core.sv */
// Top level of the breakpoint table interpolator: stream ports, controller and datapath.
`default_nettype none

// Breakpoint table interpolator over up to 64 signed Q16.16 (x, y) pairs. A write
// transaction (tuser cmd = 0) stores one pair and gives no result. A query transaction
// (cmd = 1) gives exactly one result transaction: linear, Catmull-Rom cubic (linear
// below four points) or nearest interpolation, clamped to the end ordinates outside the
// table, saturated to 32 bits. Status 1 flags fewer than two points, 2 a table whose x
// values do not strictly increase, 3 an unsupported method; the value is zero then.
// Sequence: a query first walks the n active entries through the single read port of
// the breakpoint memories, then fetches four entries; error results skip the fetch.
// Clamped and nearest results need no more; linear adds the bit-serial fraction divider
// and one multiply pass, cubic the divider and three multiply passes. A result is
// loaded only once the previous one has been taken on m_axis_tready. One query is in
// flight at a time; s_axis_tready is high while the block is idle, also while a
// finished result still waits in the output register. Write point_count only while
// idle. Entries below point_count must be written before a query. The memories have
// no reset and need no clearing pass.
module table_interpolator_core (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // point_count register
  input  wire                        cfg_we_i,
  input  wire [tic_pkg::PC_W-1:0]    cfg_wdata_i,
  // input stream
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  // [5:0] entry_index, [37:6] entry_x, [69:38] entry_y, [101:70] target_x, [103:102] zero
  input  wire [103:0]                s_axis_tdata,
  // [0] cmd, [2:1] method
  input  wire [2:0]                  s_axis_tuser,
  // result stream
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  // [31:0] value
  output logic [tic_pkg::DATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]                 m_axis_tuser
);
  import tic_pkg::*;

  tic_cmd_t cmd;
  tic_sts_t sts;

  // Sequence the query phases; hold input ready low while a query runs.
  tic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Unpack the input transaction straight into the datapath.
  tic_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_index_i   (s_axis_tdata[5:0]),
    .in_x_i       (s_axis_tdata[37:6]),
    .in_y_i       (s_axis_tdata[69:38]),
    .in_target_i  (s_axis_tdata[101:70]),
    .in_method_i  (s_axis_tuser[2:1]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* tb/table_interpolator_core_tb.sv */
// Self-checking testbench of the breakpoint table interpolator core.
`default_nettype none

module table_interpolator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tic_pkg::*;

  localparam int SETTLE_CYCLES = 150;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
  } interp_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [PC_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  // Predictor state: the breakpoint tables and the active point count.
  logic signed [31:0] bp_x [TABLE_DEPTH];
  logic signed [31:0] bp_y [TABLE_DEPTH];
  logic [PC_W-1:0] active_points;

  interp_result_t pending_results[$];
  int error_count = 0;
  int queries_sent = 0;
  int writes_sent = 0;
  int results_seen = 0;
  bit rx_idle_enable = 1'b1;
  bit tx_idle_enable = 1'b1;
  bit rx_hold = 1'b0;

  table_interpolator_core u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Floor division by 2^s for a signed value.
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic int seg_lower(int n, longint tgt);
    int i;
    i = 0;
    for (int k = 1; k + 1 < n; k++) begin
      if (bp_x[k] <= tgt) i = k;
    end
    return i;
  endfunction

  function automatic longint seg_fraction(int i, longint tgt);
    longint unsigned num;
    longint unsigned den;
    num = longint'(tgt - longint'(bp_x[i])) << FRAC_BITS;
    den = longint'(bp_x[i+1]) - longint'(bp_x[i]);
    if (den == 0) return 0;
    return longint'(num / den);
  endfunction

  function automatic longint interp_linear(int n, longint tgt);
    int i;
    longint t;
    if (tgt <= bp_x[0]) return bp_y[0];
    if (tgt >= bp_x[n-1]) return bp_y[n-1];
    i = seg_lower(n, tgt);
    t = seg_fraction(i, tgt);
    return longint'(bp_y[i]) +
           floor_shr((longint'(bp_y[i+1]) - longint'(bp_y[i])) * t, FRAC_BITS);
  endfunction

  function automatic longint interp_nearest(int n, longint tgt);
    int r;
    longint ld, rd;
    r = 0;
    while (r < n && bp_x[r] < tgt) r++;
    if (r == 0) return bp_y[0];
    if (r == n) return bp_y[n-1];
    ld = tgt - bp_x[r-1];
    rd = longint'(bp_x[r]) - tgt;
    return (ld <= rd) ? bp_y[r-1] : bp_y[r];
  endfunction

  function automatic longint interp_cubic(int n, longint tgt);
    int i0, i1, i2, i3;
    longint y0, y1, y2, y3, t, b0, b1, b2, h;
    if (n < 4) return interp_linear(n, tgt);
    if (tgt <= bp_x[0]) return bp_y[0];
    if (tgt >= bp_x[n-1]) return bp_y[n-1];
    i1 = seg_lower(n, tgt);
    i2 = i1 + 1;
    i0 = (i1 == 0) ? i1 : i1 - 1;
    i3 = (i2 + 1 < n) ? i2 + 1 : i2;
    t = seg_fraction(i1, tgt);
    y0 = bp_y[i0]; y1 = bp_y[i1]; y2 = bp_y[i2]; y3 = bp_y[i3];
    b0 = -y0 + 3 * y1 - 3 * y2 + y3;
    b1 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
    b2 = y2 - y0;
    h = b0;
    h = floor_shr(h * t, FRAC_BITS) + b1;
    h = floor_shr(h * t, FRAC_BITS) + b2;
    h = floor_shr(h * t, FRAC_BITS);
    return y1 + floor_shr(h, 1);
  endfunction

  // Compute the expected result of one query against the current table.
  function automatic interp_result_t predict_query(logic [31:0] tgt_bits, logic [1:0] meth);
    interp_result_t res;
    int n;
    longint tgt, v;
    n = (active_points > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_points);
    tgt = longint'($signed(tgt_bits));
    v = 0;
    res.status = ST_OK;
    if (n < 2) begin
      res.status = ST_FEW;
    end else begin
      for (int k = 1; k < n; k++) begin
        if (bp_x[k] <= bp_x[k-1]) res.status = ST_ORDER;
      end
      if (res.status == ST_OK) begin
        case (meth)
          METH_LINEAR:  v = interp_linear(n, tgt);
          METH_CUBIC:   v = interp_cubic(n, tgt);
          METH_NEAREST: v = interp_nearest(n, tgt);
          default:      res.status = ST_METHOD;
        endcase
      end
    end
    if (res.status != ST_OK) v = 0;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    res.value = v[31:0];
    return res;
  endfunction

  // Drive one transaction and hold it until accepted. Valid stays up until the next
  // item or an explicit drop, so it changes only once per falling edge.
  task automatic send_item(logic cmd, logic [5:0] idx, logic [31:0] ex, logic [31:0] ey,
                           logic [31:0] tgt, logic [1:0] meth);
    while (tx_idle_enable && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, tgt, ey, ex, idx};
    s_axis_tuser  <= {meth, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (cmd == CMD_WRITE) begin
      bp_x[idx] = ex;
      bp_y[idx] = ey;
      writes_sent++;
    end else begin
      pending_results.push_back(predict_query(tgt, meth));
      queries_sent++;
    end
    @(negedge clk_i);
  endtask

  task automatic write_entry(int idx, logic [31:0] ex, logic [31:0] ey);
    send_item(CMD_WRITE, idx[5:0], ex, ey, $urandom, 2'($urandom));
  endtask

  task automatic query(logic [31:0] tgt, logic [1:0] meth);
    send_item(CMD_QUERY, 6'($urandom), $urandom, $urandom, tgt, meth);
  endtask

  // Drop valid, wait for all results, let the core settle, then write the point count.
  task automatic set_point_count(int cnt);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cnt[PC_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    active_points = cnt[PC_W-1:0];
  endtask

  // Fill slots 0..n-1 with increasing x; max_step plus one bounds the gap between neighbors.
  task automatic fill_increasing(int n, int max_step);
    longint x;
    x = -longint'($urandom_range(32'h7000_0000));
    for (int k = 0; k < n; k++) begin
      write_entry(k, x[31:0], $urandom);
      x += 1 + $urandom_range(max_step);
      if (x > 64'sd2147483647) x = 64'sd2147483647 - (n - k);
    end
  endtask

  function automatic logic [31:0] pick_target(int n);
    int k;
    k = $urandom_range(n - 1);
    case ($urandom_range(4))
      0: return $urandom;
      1: return bp_x[k];
      2: return bp_x[k] + $urandom_range(3) - 1;
      default: return (k + 1 < n) ? bp_x[k] + (($signed(bp_x[k+1]) - $signed(bp_x[k])) >>> 1)
                                  : bp_x[k];
    endcase
  endfunction

  // Extremes, every method, every status, ties and end clamps.
  task automatic test_directed();
    query(32'h0, METH_LINEAR);
    set_point_count(1);
    write_entry(0, 32'h0001_0000, 32'h7FFF_FFFF);
    query(32'h8000_0000, METH_NEAREST);
    set_point_count(2);
    write_entry(1, 32'h0003_0000, 32'h8000_0000);
    query(32'h0002_0000, METH_LINEAR);
    query(32'h0002_0000, METH_NEAREST);
    query(32'h7FFF_FFFF, METH_CUBIC);
    query(32'h0001_8000, METH_BAD);
    write_entry(0, 32'h8000_0000, 32'h8000_0000);
    write_entry(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    query(32'h0, METH_LINEAR);
    query(32'hFFFF_FFFF, METH_NEAREST);
    set_point_count(4);
    write_entry(2, 32'h0, 32'h0);
    write_entry(3, 32'h0, 32'h1234_5678);
    query(32'h0, METH_LINEAR);
    write_entry(1, 32'hC000_0000, 32'h7FFF_FFFF);
    write_entry(2, 32'h0, 32'h8000_0000);
    write_entry(3, 32'h4000_0000, 32'h7FFF_FFFF);
    query(32'hE000_0000, METH_CUBIC);
    query(32'h2000_0000, METH_CUBIC);
    query(32'h8000_0000, METH_CUBIC);
    query(32'h7FFF_FFFF, METH_BAD);
    set_point_count(0);
    query(32'h0, METH_CUBIC);
  endtask

  // Random tables of varied size and random queries against each.
  task automatic test_random_tables(int total);
    int n;
    int sent;
    sent = 0;
    while (sent < total) begin
      n = ($urandom_range(9) == 0) ? TABLE_DEPTH : $urandom_range(2, 10);
      set_point_count(n);
      fill_increasing(n, ($urandom_range(1)) ? 32'h0000_4000 : 32'h0100_0000);
      sent += n;
      // Occasionally break the ordering to hit the ordering error.
      if ($urandom_range(7) == 0) begin
        write_entry($urandom_range(n - 1), $urandom, $urandom);
        sent++;
      end
      repeat ($urandom_range(4, 14)) begin
        query(pick_target(n), ($urandom_range(9) == 0) ? METH_BAD : 2'($urandom_range(2)));
        sent++;
      end
    end
    // Oversized count is clamped to the table depth.
    set_point_count(TABLE_DEPTH);
    fill_increasing(TABLE_DEPTH, 32'h0010_0000);
    set_point_count(127);
    for (int k = 0; k < 6; k++) query(pick_target(TABLE_DEPTH), 2'(k % 3));
  endtask

  // Stall the receiver for a long stretch while queries keep coming.
  task automatic test_backpressure();
    set_point_count(5);
    fill_increasing(5, 32'h0002_0000);
    rx_hold = 1'b1;
    for (int k = 0; k < 6; k++) query(pick_target(5), 2'(k % 3));
    rx_hold = 1'b0;
    // Pause the sender until everything has drained.
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    tx_idle_enable = 1'b0;
    rx_idle_enable = 1'b0;
    for (int k = 0; k < 20; k++) query(pick_target(5), 2'($urandom_range(3)));
    tx_idle_enable = 1'b1;
    rx_idle_enable = 1'b1;
  endtask

  // Receiver ready: random idling, plus a long hold counted in cycles.
  initial begin
    int hold_cycles;
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        hold_cycles = 0;
        m_axis_tready <= 1'b0;
        while (hold_cycles < 400) begin
          @(negedge clk_i);
          hold_cycles++;
        end
      end
      m_axis_tready <= !(rx_idle_enable && $urandom_range(99) < 26);
    end
  end

  // Check each result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    interp_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction value=%h status=%0d", m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.value) begin
          $error("value: expected %h, actual %h", want.value, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      bp_x[k] = '0;
      bp_y[k] = '0;
    end
    active_points = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random_tables(620);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("covered %0d writes and %0d queries, %0d results checked",
             writes_sent, queries_sent, results_seen);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
